[rtl/hdbm_pkg.sv]
package hdbm_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME_US  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_MS = 3'd4;

  localparam logic [31:0] RST_PERIOD_US     = 32'd1000000;
  localparam logic [31:0] RST_HIGH_TIME_US  = 32'd125000;
  localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd40;
  localparam logic [19:0] RST_LONG_PRESS_MS = 20'd5000;
  localparam logic [15:0] RST_BLINK_HALF_MS = 16'd250;

  localparam logic [3:0] BLINKS_ENTER_MANUAL = 4'd5;
  localparam logic [3:0] BLINKS_EXIT_MANUAL  = 4'd10;
  localparam logic [3:0] BLINKS_HEATER_ON    = 4'd1;
  localparam logic [3:0] BLINKS_HEATER_OFF   = 4'd2;

  typedef struct packed {
    logic        button_level;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        heater_on;
    logic        led_on;
    logic        manual_active;
    logic        press_seen;
    logic        release_seen;
    logic [31:0] held_time_ms;
    logic        manual_toggled;
    logic        mode_flipped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BTN,
    ST_BLINK,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic btn;
    logic blink;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_full;
  } sts_t;

endpackage

[rtl/hdbm_datapath.sv]
module hdbm_datapath
  import hdbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  // configuration
  logic [31:0] period_us;
  logic [31:0] high_time_us;
  logic [15:0] debounce_ms;
  logic [19:0] long_press_ms;
  logic [15:0] blink_half_ms;

  // captured transaction
  logic        lvl;
  logic [31:0] now_us;
  logic [31:0] now_ms;

  // controller state
  logic        manual_flag;
  logic        heater_level;
  logic [31:0] cycle_start_us;
  logic        raw_level;
  logic        stable_level;
  logic        long_press_done;
  logic [31:0] raw_change_ms;
  logic [31:0] press_start_ms;
  logic        blink_active;
  logic        blink_lit;
  logic [3:0]  blinks_left;
  logic [31:0] blink_due_ms;

  // per-transaction flags
  logic        press_seen;
  logic        release_seen;
  logic [31:0] held_ms;
  logic        toggled;
  logic        flipped;

  // modulo unit
  logic [31:0]          phase;
  logic [31:0]          dvd;
  logic [31:0]          rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  // button step results
  logic [31:0] rchg_next;
  logic        stable_next;
  logic        lpd_next;
  logic [31:0] pstart_next;
  logic        manual_next;
  logic        heater_next;
  logic [31:0] cstart_next;
  logic        press_next;
  logic        release_next;
  logic [31:0] held_next;
  logic        toggled_next;
  logic        flipped_next;
  logic        begin_next;
  logic [3:0]  begin_count;
  logic [31:0] blink_due_new;

  always_comb begin
    blink_due_new = now_ms + {16'd0, blink_half_ms};
    rchg_next     = (lvl != raw_level) ? now_ms : raw_change_ms;
    stable_next   = stable_level;
    lpd_next      = long_press_done;
    pstart_next   = press_start_ms;
    manual_next   = manual_flag;
    heater_next   = heater_level;
    cstart_next   = cycle_start_us;
    press_next    = 1'b0;
    release_next  = 1'b0;
    held_next     = '0;
    toggled_next  = 1'b0;
    flipped_next  = 1'b0;
    begin_next    = 1'b0;
    begin_count   = '0;
    if (lvl != stable_level && (now_ms - rchg_next) >= {16'd0, debounce_ms}) begin
      stable_next = lvl;
      if (!lvl) begin
        pstart_next = now_ms;
        lpd_next    = 1'b0;
        press_next  = 1'b1;
      end else begin
        release_next = 1'b1;
        held_next    = now_ms - press_start_ms;
        if (manual_flag && !long_press_done) begin
          heater_next  = !heater_level;
          begin_next   = 1'b1;
          begin_count  = heater_next ? BLINKS_HEATER_ON : BLINKS_HEATER_OFF;
          toggled_next = 1'b1;
        end
      end
    end
    if (!stable_next && !lpd_next && (now_ms - pstart_next) >= {12'd0, long_press_ms}) begin
      lpd_next     = 1'b1;
      flipped_next = 1'b1;
      manual_next  = !manual_flag;
      begin_next   = 1'b1;
      if (manual_next) begin
        heater_next = 1'b0;
        begin_count = BLINKS_ENTER_MANUAL;
      end else begin
        cstart_next = now_us;
        heater_next = 1'b1;
        begin_count = BLINKS_EXIT_MANUAL;
      end
    end
  end

  logic [3:0]  left_dec;
  logic [31:0] due_diff;
  assign due_diff = now_ms - blink_due_ms;
  assign left_dec = blinks_left - 4'd1;

  // one restoring step of the modulo
  logic [32:0] trial;
  logic [32:0] trial_sub;
  assign trial     = {rem, dvd[31]};
  assign trial_sub = trial - {1'b0, period_us};

  logic [31:0] phase_mod;
  logic        heater_final;
  assign phase_mod    = (period_us == '0) ? phase : rem;
  assign heater_final = manual_flag ? heater_level : (phase_mod < high_time_us);

  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_us     <= RST_PERIOD_US;
      high_time_us  <= RST_HIGH_TIME_US;
      debounce_ms   <= RST_DEBOUNCE_MS;
      long_press_ms <= RST_LONG_PRESS_MS;
      blink_half_ms <= RST_BLINK_HALF_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD_US:     period_us     <= cfg_data;
        REG_HIGH_TIME_US:  high_time_us  <= cfg_data;
        REG_DEBOUNCE_MS:   debounce_ms   <= cfg_data[15:0];
        REG_LONG_PRESS_MS: long_press_ms <= cfg_data[19:0];
        REG_BLINK_HALF_MS: blink_half_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_flag     <= 1'b0;
      heater_level    <= 1'b0;
      cycle_start_us  <= '0;
      raw_level       <= 1'b1;
      stable_level    <= 1'b1;
      long_press_done <= 1'b0;
      raw_change_ms   <= '0;
      press_start_ms  <= '0;
      blink_active    <= 1'b0;
      blink_lit       <= 1'b0;
      blinks_left     <= '0;
      blink_due_ms    <= '0;
      out_valid       <= 1'b0;
      div_cnt         <= '0;
    end else begin
      if (cmd.btn) begin
        raw_level       <= lvl;
        raw_change_ms   <= rchg_next;
        stable_level    <= stable_next;
        long_press_done <= lpd_next;
        press_start_ms  <= pstart_next;
        manual_flag     <= manual_next;
        heater_level    <= heater_next;
        cycle_start_us  <= cstart_next;
        if (begin_next) begin
          blinks_left  <= begin_count;
          blink_active <= 1'b1;
          blink_lit    <= 1'b1;
          blink_due_ms <= blink_due_new;
        end
      end
      if (cmd.blink) begin
        div_cnt <= '0;
        if (blink_active && !due_diff[31]) begin
          if (blink_lit) begin
            blink_lit    <= 1'b0;
            blink_due_ms <= blink_due_new;
          end else begin
            blinks_left <= left_dec;
            if (left_dec == '0) begin
              blink_active <= 1'b0;
            end else begin
              blink_lit    <= 1'b1;
              blink_due_ms <= blink_due_new;
            end
          end
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.finish) begin
        heater_level <= heater_final;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl    <= in_data.button_level;
      now_us <= in_data.now_us;
      now_ms <= in_data.now_ms;
    end
    if (cmd.btn) begin
      press_seen   <= press_next;
      release_seen <= release_next;
      held_ms      <= held_next;
      toggled      <= toggled_next;
      flipped      <= flipped_next;
    end
    if (cmd.blink) begin
      phase <= now_us - cycle_start_us;
      dvd   <= now_us - cycle_start_us;
      rem   <= '0;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
    end
    if (cmd.finish) begin
      out_data.heater_on      <= heater_final;
      out_data.led_on         <= blink_lit;
      out_data.manual_active  <= manual_flag;
      out_data.press_seen     <= press_seen;
      out_data.release_seen   <= release_seen;
      out_data.held_time_ms   <= held_ms;
      out_data.manual_toggled <= toggled;
      out_data.mode_flipped   <= flipped;
    end
  end

  // a finished blink run leaves the LED dark with nothing pending
  assert property (@(posedge clk) disable iff (rst)
    !blink_active |-> (blinks_left == '0) && !blink_lit)
    else $error("idle blink run holds a count or lit LED");

  assert property (@(posedge clk) disable iff (rst)
    blink_active |-> (blinks_left != '0))
    else $error("active blink run with zero count");

  // a result is never written over one that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwritten before transaction");

endmodule

[rtl/hdbm_ctrl.sv]
module hdbm_ctrl
  import hdbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_BTN;
      ST_BTN:   state_next = ST_BLINK;
      ST_BLINK: state_next = ST_DIV;
      ST_DIV:   if (sts.div_last) state_next = ST_FIN;
      ST_FIN:   if (!sts.out_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_BTN:   cmd.btn = 1'b1;
      ST_BLINK: cmd.blink = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.finish = !sts.out_full;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_BTN)
    else $error("accepted transaction did not start the button step");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && sts.div_last |=> state == ST_FIN)
    else $error("modulo did not end after its last step");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && !sts.out_full |=> state == ST_IDLE)
    else $error("result stage did not release");

endmodule

[rtl/heater_duty_with_button_mode_control.sv]
// each input runs in turn through the button, blink, modulo and result steps,
//   the modulo being a 32-step restoring modulo of the elapsed time by period_us;
//   no new input is taken until the result step of the last one is done
// an input is taken while an earlier result still waits in the output register
// reset (rst, synchronous): auto mode, heater off, button released, LED dark,
//   registers at their defaults
module heater_duty_with_button_mode_control
  import hdbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  hdbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdbm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[tb/tb_heater_duty_with_button_mode_control.sv]
`timescale 1ns / 1ps

import hdbm_pkg::*;

class duty_scoreboard;
  bit [31:0] period_us;
  bit [31:0] high_time_us;
  bit [15:0] debounce_ms;
  bit [19:0] long_press_ms;
  bit [15:0] blink_half_ms;

  bit        manual;
  bit        heater;
  bit [31:0] cycle_start_us;
  bit        raw_lvl;
  bit        stable_lvl;
  bit        long_done;
  bit [31:0] raw_change_ms;
  bit [31:0] press_start_ms;
  bit        blink_run;
  bit        blink_lit;
  bit [3:0]  blinks_left;
  bit [31:0] blink_due_ms;

  out_item_t outputs_due[$];
  int        fails;

  function new();
    period_us      = RST_PERIOD_US;
    high_time_us   = RST_HIGH_TIME_US;
    debounce_ms    = RST_DEBOUNCE_MS;
    long_press_ms  = RST_LONG_PRESS_MS;
    blink_half_ms  = RST_BLINK_HALF_MS;
    manual         = 1'b0;
    heater         = 1'b0;
    cycle_start_us = '0;
    raw_lvl        = 1'b1;
    stable_lvl     = 1'b1;
    long_done      = 1'b0;
    raw_change_ms  = '0;
    press_start_ms = '0;
    blink_run      = 1'b0;
    blink_lit      = 1'b0;
    blinks_left    = '0;
    blink_due_ms   = '0;
    fails          = 0;
  endfunction

  // narrower registers keep only their low bits, unmapped indexes are dropped
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PERIOD_US:     period_us     = data;
      REG_HIGH_TIME_US:  high_time_us  = data;
      REG_DEBOUNCE_MS:   debounce_ms   = data[15:0];
      REG_LONG_PRESS_MS: long_press_ms = data[19:0];
      REG_BLINK_HALF_MS: blink_half_ms = data[15:0];
      default: ;
    endcase
  endfunction

  function void start_blinks(bit [3:0] count, bit [31:0] now_ms);
    blinks_left  = count;
    blink_run    = count != 0;
    blink_lit    = blink_run;
    blink_due_ms = now_ms + blink_half_ms;
  endfunction

  function void advance_blinks(bit [31:0] now_ms);
    bit [31:0] late;
    late = now_ms - blink_due_ms;
    // deadline counts as reached when the wrapped difference is not negative
    if (!blink_run || late[31]) return;
    if (blink_lit) begin
      blink_lit    = 1'b0;
      blink_due_ms = now_ms + blink_half_ms;
      return;
    end
    blinks_left = blinks_left - 1'b1;
    if (blinks_left == 0) begin
      blink_run = 1'b0;
      return;
    end
    blink_lit    = 1'b1;
    blink_due_ms = now_ms + blink_half_ms;
  endfunction

  function out_item_t heater_step(in_item_t it);
    out_item_t r;
    bit [31:0] now_ms;
    bit [31:0] now_us;
    bit [31:0] since_change;
    bit [31:0] since_press;
    bit [31:0] phase;
    r      = '0;
    now_ms = it.now_ms;
    now_us = it.now_us;
    if (it.button_level != raw_lvl) begin
      raw_lvl       = it.button_level;
      raw_change_ms = now_ms;
    end
    since_change = now_ms - raw_change_ms;
    if (raw_lvl != stable_lvl && since_change >= debounce_ms) begin
      stable_lvl = raw_lvl;
      if (!stable_lvl) begin
        press_start_ms = now_ms;
        long_done      = 1'b0;
        r.press_seen   = 1'b1;
      end else begin
        r.release_seen = 1'b1;
        r.held_time_ms = now_ms - press_start_ms;
        // a release that ends a long press leaves the heater alone
        if (manual && !long_done) begin
          heater = !heater;
          start_blinks(heater ? BLINKS_HEATER_ON : BLINKS_HEATER_OFF, now_ms);
          r.manual_toggled = 1'b1;
        end
      end
    end
    since_press = now_ms - press_start_ms;
    if (!stable_lvl && !long_done && since_press >= long_press_ms) begin
      long_done      = 1'b1;
      r.mode_flipped = 1'b1;
      manual         = !manual;
      if (manual) begin
        heater = 1'b0;
        start_blinks(BLINKS_ENTER_MANUAL, now_ms);
      end else begin
        cycle_start_us = now_us;
        heater         = 1'b1;
        start_blinks(BLINKS_EXIT_MANUAL, now_ms);
      end
    end
    advance_blinks(now_ms);
    if (!manual) begin
      phase = now_us - cycle_start_us;
      if (period_us != 0) phase = phase % period_us;
      heater = phase < high_time_us;
    end
    r.heater_on     = heater;
    r.led_on        = blink_lit;
    r.manual_active = manual;
    return r;
  endfunction

  function void note_input(in_item_t it);
    outputs_due.push_back(heater_step(it));
  endfunction

  function void compare_field(string field, bit [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, seen);
      fails++;
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (outputs_due.size() == 0) begin
      $error("result transaction with no input pending: %0h", got);
      fails++;
      return;
    end
    want = outputs_due.pop_front();
    compare_field("heater_on", want.heater_on, got.heater_on);
    compare_field("led_on", want.led_on, got.led_on);
    compare_field("manual_active", want.manual_active, got.manual_active);
    compare_field("press_seen", want.press_seen, got.press_seen);
    compare_field("release_seen", want.release_seen, got.release_seen);
    compare_field("held_time_ms", want.held_time_ms, got.held_time_ms);
    compare_field("manual_toggled", want.manual_toggled, got.manual_toggled);
    compare_field("mode_flipped", want.mode_flipped, got.mode_flipped);
  endfunction
endclass

module tb_heater_duty_with_button_mode_control;
  import hdbm_pkg::*;

  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 48;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int IDLE_PCT_HEAVY  = 61;
  localparam int IDLE_PCT_LIGHT  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  duty_scoreboard sb;
  int             idle_cycles = 0;
  int             gap_pct = 0;
  int             stall_pct = 0;
  int             sent = 0;
  bit [31:0]      t_ms;
  bit [31:0]      t_us;

  heater_duty_with_button_mode_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
    idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(bit level, bit [31:0] us, bit [31:0] ms);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid             = 1'b1;
    in_data.button_level = level;
    in_data.now_us       = us;
    in_data.now_ms       = ms;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic advance(int unsigned dt_ms, bit level);
    t_ms = t_ms + dt_ms;
    t_us = t_us + dt_ms * 1000 + $urandom_range(0, 999);
    send_item(level, t_us, t_ms);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(bit [31:0] per, bit [31:0] hi, bit [31:0] db, bit [31:0] lp,
                              bit [31:0] bh);
    write_reg(REG_PERIOD_US, per);
    write_reg(REG_HIGH_TIME_US, hi);
    write_reg(3'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), $urandom);
    write_reg(REG_DEBOUNCE_MS, db);
    write_reg(REG_LONG_PRESS_MS, lp);
    write_reg(REG_BLINK_HALF_MS, bh);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_config();
    bit [31:0] per;
    bit [31:0] hi;
    bit [15:0] db;
    bit [19:0] lp;
    bit [15:0] bh;
    case ($urandom_range(0, 4))
      0: per = 1;
      1: per = $urandom_range(2, 5000);
      2: per = $urandom_range(1000, 2000000);
      3: per = $urandom;
      default: per = 0;
    endcase
    case ($urandom_range(0, 3))
      0: hi = $urandom_range(0, per);
      1: hi = $urandom;
      2: hi = per / 2;
      default: hi = 0;
    endcase
    db = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
    lp = 20'($urandom_range(1, 400));
    bh = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 120));
    // junk above each register's width must be dropped
    program_regs(per, hi, ($urandom & 32'hFFFF_0000) | db, ($urandom & 32'hFFF0_0000) | lp,
                 ($urandom & 32'hFFFF_0000) | bh);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin gap_pct = 0;              stall_pct = 0;              end
      1: begin gap_pct = IDLE_PCT_HEAVY; stall_pct = 0;              end
      2: begin gap_pct = 0;              stall_pct = IDLE_PCT_HEAVY; end
      default: begin gap_pct = IDLE_PCT_LIGHT; stall_pct = IDLE_PCT_LIGHT; end
    endcase
  endtask

  // bouncy press, hold short or past the long press time, bouncy release, then idle
  task automatic press_episode();
    int unsigned db;
    int unsigned lp;
    int unsigned bh;
    int unsigned hold;
    int unsigned spent;
    int unsigned dt;
    db = sb.debounce_ms;
    lp = sb.long_press_ms;
    bh = sb.blink_half_ms;
    repeat ($urandom_range(0, 3)) advance($urandom_range(0, db), 1'($urandom_range(0, 1)));
    advance(db + $urandom_range(0, 2), 1'b0);
    if ($urandom_range(0, 99) < 40) hold = lp + $urandom_range(0, 3 * bh);
    else hold = (lp == 0) ? 0 : $urandom_range(0, lp - 1);
    spent = 0;
    while (spent < hold) begin
      dt = $urandom_range(1, hold - spent);
      advance(dt, 1'b0);
      spent += dt;
    end
    repeat ($urandom_range(0, 2)) advance($urandom_range(0, db), 1'($urandom_range(0, 1)));
    advance(db + $urandom_range(0, 2), 1'b1);
    repeat ($urandom_range(1, 8)) advance($urandom_range(0, 2 * bh + 1), 1'b1);
  endtask

  task automatic run_random(int count);
    int first;
    first = sent;
    while (sent - first < count) begin
      if ($urandom_range(0, 99) < 80) press_episode();
      else repeat ($urandom_range(1, 4)) send_item(1'($urandom_range(0, 1)), $urandom, $urandom);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_PERIOD_US;
    cfg_data  = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: zero period, zero blink half, instant debounce, wrapping timestamps
    program_regs(32'd0, 32'd500, 32'd0, 32'd2, 32'd0);
    send_item(1'b1, 32'd0, 32'd0);
    send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
    send_item(1'b0, 32'd100, 32'hFFFF_FFFE);
    send_item(1'b0, 32'd200, 32'd0);
    send_item(1'b1, 32'd300, 32'd1);
    send_item(1'b1, 32'd310, 32'd2);
    send_item(1'b1, 32'd320, 32'd3);
    send_item(1'b1, 32'd330, 32'd4);
    send_item(1'b0, 32'd340, 32'd5);
    send_item(1'b1, 32'd350, 32'd6);
    send_item(1'b1, 32'd360, 32'd7);
    send_item(1'b0, 32'd370, 32'd8);
    send_item(1'b1, 32'd380, 32'd9);
    send_item(1'b1, 32'd390, 32'd10);
    send_item(1'b0, 32'd400, 32'd11);
    send_item(1'b0, 32'd1000, 32'd13);
    send_item(1'b1, 32'd1499, 32'd14);
    send_item(1'b1, 32'd1500, 32'd15);
    send_item(1'b1, 32'hFFFF_FFFF, 32'd16);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h000F_FFFF,
                        32'h0000_FFFF);
        1: program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        2: program_regs(RST_PERIOD_US, RST_HIGH_TIME_US, 32'(RST_DEBOUNCE_MS),
                        32'(RST_LONG_PRESS_MS), 32'(RST_BLINK_HALF_MS));
        default: random_config();
      endcase
      set_idling(p % 4);
      t_ms = $urandom;
      t_us = $urandom;
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    if (sb.fails == 0 && sb.outputs_due.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
